>>> sv/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the command frame parser: register indexes,
// parse phases, sequencer steps and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

   localparam int PAYLOAD_DEPTH = 64;
   localparam int GAP_TICKS     = 25;

   localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
   localparam int IDLE_W = $clog2(GAP_TICKS + 2);

   localparam logic [IDLE_W-1:0] GAP_LIMIT  = IDLE_W'(GAP_TICKS);
   localparam logic [7:0]        DEPTH_BYTE = 8'(PAYLOAD_DEPTH);

   // configuration register indexes
   localparam logic [2:0] CSR_PRODUCT_ID_FIRST    = 3'd0;
   localparam logic [2:0] CSR_PRODUCT_ID_SECOND   = 3'd1;
   localparam logic [2:0] CSR_OWN_ADDRESS         = 3'd2;
   localparam logic [2:0] CSR_GLOBAL_ADDRESS      = 3'd3;
   localparam logic [2:0] CSR_ADDRESS_LIMIT       = 3'd4;
   localparam logic [2:0] CSR_COMMAND_MODE_ACTIVE = 3'd5;
   localparam logic [2:0] CSR_MODE_COMMAND_CODE   = 3'd6;
   localparam logic [2:0] CSR_COMMAND_LIMIT       = 3'd7;

   // result status codes
   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd2;

   // command/type byte length codes; KIND_COUNT announces a count byte
   localparam logic [1:0] KIND_ONE   = 2'd0;
   localparam logic [1:0] KIND_TWO   = 2'd1;
   localparam logic [1:0] KIND_FOUR  = 2'd2;
   localparam logic [1:0] KIND_COUNT = 2'd3;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_ADDR,
      PH_PID2,
      PH_CMD,
      PH_COUNT,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CHK0,
      SEQ_CHK1,
      SEQ_CHK2,
      SEQ_CHK3,
      SEQ_SUM
   } seq_type;

   typedef enum logic [1:0] {
      RD_IDLE,
      RD_SINGLE,
      RD_FETCH,
      RD_LOAD
   } rd_state_type;

   typedef struct packed {
      logic [7:0] product_id_first;
      logic [7:0] product_id_second;
      logic [7:0] own_address;
      logic [7:0] global_address;
      logic [7:0] address_limit;
      logic       command_mode_active;
      logic [5:0] mode_command_code;
      logic [6:0] command_limit;
   } cfg_type;

   typedef struct packed {
      logic [7:0] sum;
      logic       eq;
      logic       lt;
   } unit_res_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ram_wr_type;

   typedef struct packed {
      logic       start;
      logic [1:0] status;
      logic [5:0] command;
      logic [6:0] count;
      logic       multi;
   } rd_req_type;

endpackage

`default_nettype wire

>>> sv/cfp_cmp_unit.sv
// ----------------------------------------------------------------------------
// cfp_cmp_unit
// Shared 8-bit add and compare unit used by the parse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_cmp_unit (
   input  wire logic [7:0]           op_a,
   input  wire logic [7:0]           op_b,
   output cfp_pkg::unit_res_type     res
);

   always_comb begin
      res.sum = op_a + op_b;
      res.eq  = (op_a == op_b);
      res.lt  = (op_a < op_b);
   end

endmodule

`default_nettype wire

>>> sv/cfp_payload_ram.sv
// ----------------------------------------------------------------------------
// cfp_payload_ram
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_payload_ram (
   input  wire logic                       clock,
   input  wire cfp_pkg::ram_wr_type        wr,
   input  wire logic [cfp_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                      rd_data
);

   logic [7:0] mem [cfp_pkg::PAYLOAD_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/cfp_parser.sv
// ----------------------------------------------------------------------------
// cfp_parser
// Frame parse sequencer: takes one transaction; for a byte it then steps the
// shared compare/add unit through the checks of the current phase.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfp_pkg::cfg_type     cfg,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_operation,
   input  wire logic [7:0]           req_rx_byte,
   input  wire logic                 rd_busy,
   output cfp_pkg::ram_wr_type       ram_wr,
   output cfp_pkg::rd_req_type       rd_req
);

   cfp_pkg::phase_type        phase_ff, phase_in;
   cfp_pkg::seq_type          seq_ff, seq_in;
   logic [7:0]                sum_ff, sum_in;
   logic [5:0]                cmd_ff, cmd_in;
   logic [6:0]                expected_ff, expected_in;
   logic [6:0]                received_ff, received_in;
   logic [cfp_pkg::IDLE_W-1:0] idle_ff, idle_in;
   logic [7:0]                rx_ff, rx_in;
   logic                      hit_ff, hit_in;
   logic                      aux_ff, aux_in;

   logic [7:0]                op_a;
   logic [7:0]                op_b;
   cfp_pkg::unit_res_type     res;
   logic                      accept;

   cfp_cmp_unit u_unit (
      .op_a (op_a),
      .op_b (op_b),
      .res  (res)
   );

   assign req_stall = (seq_ff != cfp_pkg::SEQ_IDLE) || rd_busy;
   assign accept    = req_valid && !req_stall;

   // operand selection for the shared unit
   always_comb begin
      op_a = sum_ff;
      op_b = rx_ff;
      if (seq_ff == cfp_pkg::SEQ_SUM) begin
         op_a = (phase_ff == cfp_pkg::PH_ADDR) ? cfg.product_id_first : sum_ff;
         op_b = rx_ff;
      end else begin
         case (phase_ff)
            cfp_pkg::PH_ADDR: begin
               case (seq_ff)
                  cfp_pkg::SEQ_CHK0: begin
                     op_a = rx_ff;
                     op_b = cfg.global_address;
                  end
                  cfp_pkg::SEQ_CHK1: begin
                     op_a = cfg.own_address;
                     op_b = cfg.global_address;
                  end
                  cfp_pkg::SEQ_CHK2: begin
                     op_a = rx_ff;
                     op_b = cfg.address_limit;
                  end
                  default: begin
                     op_a = rx_ff;
                     op_b = cfg.own_address;
                  end
               endcase
            end
            cfp_pkg::PH_PID2: begin
               op_a = rx_ff;
               op_b = cfg.product_id_second;
            end
            cfp_pkg::PH_CMD: begin
               op_a = {2'b00, rx_ff[7:2]};
               op_b = (seq_ff == cfp_pkg::SEQ_CHK0) ? {2'b00, cfg.mode_command_code}
                                                    : {1'b0, cfg.command_limit};
            end
            cfp_pkg::PH_COUNT: begin
               op_a = cfp_pkg::DEPTH_BYTE;
               op_b = rx_ff;
            end
            cfp_pkg::PH_DATA: begin
               if (seq_ff == cfp_pkg::SEQ_CHK0) begin
                  op_a = {1'b0, received_ff};
                  op_b = {1'b0, expected_ff};
               end else begin
                  op_a = rx_ff;
                  op_b = sum_ff;
               end
            end
            default: begin
               op_a = rx_ff;
               op_b = cfg.product_id_first;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= cfp_pkg::PH_HUNT;
         seq_ff      <= cfp_pkg::SEQ_IDLE;
         sum_ff      <= '0;
         cmd_ff      <= '0;
         expected_ff <= '0;
         received_ff <= '0;
         idle_ff     <= '0;
         hit_ff      <= 1'b0;
         aux_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         seq_ff      <= seq_in;
         sum_ff      <= sum_in;
         cmd_ff      <= cmd_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
         idle_ff     <= idle_in;
         hit_ff      <= hit_in;
         aux_ff      <= aux_in;
      end
      rx_ff <= rx_in;
   end

   always_comb begin
      phase_in    = phase_ff;
      seq_in      = seq_ff;
      sum_in      = sum_ff;
      cmd_in      = cmd_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      idle_in     = idle_ff;
      rx_in       = rx_ff;
      hit_in      = hit_ff;
      aux_in      = aux_ff;
      ram_wr      = '{en: 1'b0, addr: received_ff[cfp_pkg::ADDR_W-1:0], data: rx_ff};
      rd_req      = '{start: 1'b0, status: cfp_pkg::STATUS_GOOD, command: cmd_ff,
                      count: expected_ff, multi: 1'b0};

      if (seq_ff == cfp_pkg::SEQ_IDLE) begin
         if (accept) begin
            if (req_operation == cfp_pkg::OP_TICK) begin
               if (idle_ff <= cfp_pkg::GAP_LIMIT) begin
                  idle_in = idle_ff + 1'b1;
               end
            end else begin
               idle_in = '0;
               rx_in   = req_rx_byte;
               seq_in  = cfp_pkg::SEQ_CHK0;
               // gap timeout: restart hunting before looking at this byte
               if (idle_ff > cfp_pkg::GAP_LIMIT) begin
                  phase_in = cfp_pkg::PH_HUNT;
               end
            end
         end
      end else begin
         case (phase_ff)
            cfp_pkg::PH_ADDR: begin
               case (seq_ff)
                  cfp_pkg::SEQ_CHK0: begin
                     hit_in = res.eq;
                     seq_in = cfp_pkg::SEQ_CHK1;
                  end
                  cfp_pkg::SEQ_CHK1: begin
                     aux_in = res.eq;
                     seq_in = cfp_pkg::SEQ_CHK2;
                  end
                  cfp_pkg::SEQ_CHK2: begin
                     if (aux_ff && res.lt) begin
                        hit_in = 1'b1;
                     end
                     seq_in = cfp_pkg::SEQ_CHK3;
                  end
                  cfp_pkg::SEQ_CHK3: begin
                     if (hit_ff || res.eq) begin
                        seq_in = cfp_pkg::SEQ_SUM;
                     end else begin
                        phase_in = cfp_pkg::PH_HUNT;
                        seq_in   = cfp_pkg::SEQ_CHK0;
                     end
                  end
                  default: begin
                     sum_in   = res.sum;
                     phase_in = cfp_pkg::PH_PID2;
                     seq_in   = cfp_pkg::SEQ_IDLE;
                  end
               endcase
            end
            cfp_pkg::PH_PID2: begin
               if (seq_ff == cfp_pkg::SEQ_SUM) begin
                  sum_in   = res.sum;
                  phase_in = cfp_pkg::PH_CMD;
                  seq_in   = cfp_pkg::SEQ_IDLE;
               end else if (res.eq) begin
                  seq_in = cfp_pkg::SEQ_SUM;
               end else begin
                  phase_in = cfp_pkg::PH_HUNT;
                  seq_in   = cfp_pkg::SEQ_CHK0;
               end
            end
            cfp_pkg::PH_CMD: begin
               case (seq_ff)
                  cfp_pkg::SEQ_CHK0: begin
                     hit_in = cfg.command_mode_active || res.eq;
                     seq_in = cfp_pkg::SEQ_CHK1;
                  end
                  cfp_pkg::SEQ_SUM: begin
                     sum_in      = res.sum;
                     cmd_in      = rx_ff[7:2];
                     received_in = '0;
                     seq_in      = cfp_pkg::SEQ_IDLE;
                     phase_in    = cfp_pkg::PH_DATA;
                     case (rx_ff[1:0])
                        cfp_pkg::KIND_ONE:   expected_in = 7'd1;
                        cfp_pkg::KIND_TWO:   expected_in = 7'd2;
                        cfp_pkg::KIND_FOUR:  expected_in = 7'd4;
                        cfp_pkg::KIND_COUNT: phase_in    = cfp_pkg::PH_COUNT;
                        default:             phase_in    = cfp_pkg::PH_COUNT;
                     endcase
                  end
                  default: begin
                     if (hit_ff && res.lt) begin
                        seq_in = cfp_pkg::SEQ_SUM;
                     end else begin
                        phase_in = cfp_pkg::PH_HUNT;
                        seq_in   = cfp_pkg::SEQ_CHK0;
                     end
                  end
               endcase
            end
            cfp_pkg::PH_COUNT: begin
               if (seq_ff == cfp_pkg::SEQ_SUM) begin
                  sum_in = res.sum;
                  seq_in = cfp_pkg::SEQ_IDLE;
                  if (aux_ff) begin
                     phase_in      = cfp_pkg::PH_HUNT;
                     rd_req.start  = 1'b1;
                     rd_req.status = cfp_pkg::STATUS_OVERSIZE;
                     rd_req.count  = '0;
                  end else begin
                     expected_in = rx_ff[6:0];
                     phase_in    = cfp_pkg::PH_DATA;
                  end
               end else begin
                  // depth below the count byte means the frame is too large
                  aux_in = res.lt;
                  seq_in = cfp_pkg::SEQ_SUM;
               end
            end
            cfp_pkg::PH_DATA: begin
               case (seq_ff)
                  cfp_pkg::SEQ_CHK0: begin
                     if (res.lt) begin
                        ram_wr.en = 1'b1;
                        seq_in    = cfp_pkg::SEQ_SUM;
                     end else begin
                        seq_in = cfp_pkg::SEQ_CHK1;
                     end
                  end
                  cfp_pkg::SEQ_SUM: begin
                     sum_in      = res.sum;
                     received_in = received_ff + 7'd1;
                     seq_in      = cfp_pkg::SEQ_IDLE;
                  end
                  default: begin
                     // checksum byte
                     phase_in     = cfp_pkg::PH_HUNT;
                     seq_in       = cfp_pkg::SEQ_IDLE;
                     rd_req.start = 1'b1;
                     if (!res.eq) begin
                        rd_req.status = cfp_pkg::STATUS_CHECKSUM;
                     end else if (expected_ff != '0) begin
                        rd_req.multi = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               phase_in = res.eq ? cfp_pkg::PH_ADDR : cfp_pkg::PH_HUNT;
               seq_in   = cfp_pkg::SEQ_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> sv/cfp_readout.sv
// ----------------------------------------------------------------------------
// cfp_readout
// Result sequencer: sends a single status result or walks the payload store
// one entry at a time into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfp_readout (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cfp_pkg::rd_req_type        rd_req,
   output logic                            rd_busy,
   output logic [cfp_pkg::ADDR_W-1:0]      rd_addr,
   input  wire logic [7:0]                 rd_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [5:0]                      rsp_command,
   output logic [6:0]                      rsp_payload_count,
   output logic                            rsp_has_payload,
   output logic [5:0]                      rsp_payload_index,
   output logic [7:0]                      rsp_payload_byte,
   output logic                            rsp_last
);

   cfp_pkg::rd_state_type       state_ff, state_in;
   logic [1:0]                  status_ff, status_in;
   logic [5:0]                  cmd_ff, cmd_in;
   logic [6:0]                  count_ff, count_in;
   logic [cfp_pkg::ADDR_W-1:0]  idx_ff, idx_in;

   logic                        valid_ff, valid_in;
   logic [1:0]                  o_status_ff, o_status_in;
   logic [5:0]                  o_cmd_ff, o_cmd_in;
   logic [6:0]                  o_count_ff, o_count_in;
   logic                        o_hp_ff, o_hp_in;
   logic [5:0]                  o_idx_ff, o_idx_in;
   logic [7:0]                  o_byte_ff, o_byte_in;
   logic                        o_last_ff, o_last_in;

   logic                        slot_free;
   logic                        is_last;

   assign slot_free = !valid_ff || !rsp_stall;
   assign is_last   = (({1'b0, 6'(idx_ff)}) + 7'd1) == count_ff;
   assign rd_busy   = (state_ff != cfp_pkg::RD_IDLE);
   assign rd_addr   = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfp_pkg::RD_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      status_ff   <= status_in;
      cmd_ff      <= cmd_in;
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      o_status_ff <= o_status_in;
      o_cmd_ff    <= o_cmd_in;
      o_count_ff  <= o_count_in;
      o_hp_ff     <= o_hp_in;
      o_idx_ff    <= o_idx_in;
      o_byte_ff   <= o_byte_in;
      o_last_ff   <= o_last_in;
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      cmd_in      = cmd_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      valid_in    = valid_ff;
      o_status_in = o_status_ff;
      o_cmd_in    = o_cmd_ff;
      o_count_in  = o_count_ff;
      o_hp_in     = o_hp_ff;
      o_idx_in    = o_idx_ff;
      o_byte_in   = o_byte_ff;
      o_last_in   = o_last_ff;

      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         cfp_pkg::RD_IDLE: begin
            if (rd_req.start) begin
               status_in = rd_req.status;
               cmd_in    = rd_req.command;
               count_in  = rd_req.count;
               idx_in    = '0;
               state_in  = rd_req.multi ? cfp_pkg::RD_FETCH : cfp_pkg::RD_SINGLE;
            end
         end
         cfp_pkg::RD_SINGLE: begin
            if (slot_free) begin
               valid_in    = 1'b1;
               o_status_in = status_ff;
               o_cmd_in    = cmd_ff;
               o_count_in  = count_ff;
               o_hp_in     = 1'b0;
               o_idx_in    = '0;
               o_byte_in   = '0;
               o_last_in   = 1'b1;
               state_in    = cfp_pkg::RD_IDLE;
            end
         end
         cfp_pkg::RD_FETCH: begin
            // store read of idx_ff lands in rd_data next cycle
            state_in = cfp_pkg::RD_LOAD;
         end
         default: begin
            if (slot_free) begin
               valid_in    = 1'b1;
               o_status_in = status_ff;
               o_cmd_in    = cmd_ff;
               o_count_in  = count_ff;
               o_hp_in     = 1'b1;
               o_idx_in    = 6'(idx_ff);
               o_byte_in   = rd_data;
               o_last_in   = is_last;
               if (is_last) begin
                  state_in = cfp_pkg::RD_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = cfp_pkg::RD_FETCH;
               end
            end
         end
      endcase
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = o_status_ff;
   assign rsp_command       = o_cmd_ff;
   assign rsp_payload_count = o_count_ff;
   assign rsp_has_payload   = o_hp_ff;
   assign rsp_payload_index = o_idx_ff;
   assign rsp_payload_byte  = o_byte_ff;
   assign rsp_last          = o_last_ff;

endmodule

`default_nettype wire

>>> sv/command_frame_parser.sv
// ----------------------------------------------------------------------------
// command_frame_parser
// Parses command frames from UART bytes and tick transactions and reports
// each accepted frame as a run of results.
//
//   channel   direction  ports                              handshake
//   req_      in         operation, rx_byte                 valid / stall
//   rsp_      out        status .. last (seven fields)      valid / stall
//   csr_      in         write enable, index, data          write only
//
// A byte is handled by the parse sequencer stepping the shared compare/add
// unit, the address byte taking the most steps; a rejected byte is checked
// again as a frame start in place of the sum step. A good frame with payload
// then reads the payload store one entry per fetch and load; any other
// result is sent as a single status result; req_stall is high meanwhile.
// Reset is synchronous; no clearing pass, the payload store is not reset.
// A stalled result holds the readout; input stays stalled until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_operation,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [5:0]      rsp_command,
   output logic [6:0]      rsp_payload_count,
   output logic            rsp_has_payload,
   output logic [5:0]      rsp_payload_index,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_last,
   input  wire logic       csr_wen,
   input  wire logic [2:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   cfp_pkg::cfg_type             cfg_ff, cfg_in;
   cfp_pkg::ram_wr_type          ram_wr;
   cfp_pkg::rd_req_type          rd_req;
   logic                         rd_busy;
   logic [cfp_pkg::ADDR_W-1:0]   rd_addr;
   logic [7:0]                   rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.product_id_first    <= 8'd0;
         cfg_ff.product_id_second   <= 8'd0;
         cfg_ff.own_address         <= 8'd0;
         cfg_ff.global_address      <= 8'd255;
         cfg_ff.address_limit       <= 8'd16;
         cfg_ff.command_mode_active <= 1'b0;
         cfg_ff.mode_command_code   <= 6'd1;
         cfg_ff.command_limit       <= 7'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            cfp_pkg::CSR_PRODUCT_ID_FIRST:    cfg_in.product_id_first    = csr_wdata;
            cfp_pkg::CSR_PRODUCT_ID_SECOND:   cfg_in.product_id_second   = csr_wdata;
            cfp_pkg::CSR_OWN_ADDRESS:         cfg_in.own_address         = csr_wdata;
            cfp_pkg::CSR_GLOBAL_ADDRESS:      cfg_in.global_address      = csr_wdata;
            cfp_pkg::CSR_ADDRESS_LIMIT:       cfg_in.address_limit       = csr_wdata;
            cfp_pkg::CSR_COMMAND_MODE_ACTIVE: cfg_in.command_mode_active = csr_wdata[0];
            cfp_pkg::CSR_MODE_COMMAND_CODE:   cfg_in.mode_command_code   = csr_wdata[5:0];
            cfp_pkg::CSR_COMMAND_LIMIT:       cfg_in.command_limit       = csr_wdata[6:0];
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   cfp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .rd_busy       (rd_busy),
      .ram_wr        (ram_wr),
      .rd_req        (rd_req)
   );

   cfp_payload_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cfp_readout u_readout (
      .clock             (clock),
      .reset             (reset),
      .rd_req            (rd_req),
      .rd_busy           (rd_busy),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command       (rsp_command),
      .rsp_payload_count (rsp_payload_count),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire
